// ----- hdl/gmbl_pkg.sv -----
// Package for the bilinear grid lookup: sizes, item kinds, helpers.
// No dependencies.
package gmbl_pkg;

    localparam int MAX_X_POINTS_DEF = 64;
    localparam int MAX_Z_POINTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int IN_W      = 32;
    localparam int SLOT_W    = 12;
    localparam int CNT_W     = 7;
    localparam int WEIGHT_W  = 17;
    localparam int FRAC_W    = 16;
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        KIND_LOAD_X = 2'd0,
        KIND_LOAD_Z = 2'd1,
        KIND_LOAD_G = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_X_COUNT = 2'd0,
        REG_Z_COUNT = 2'd1,
        REG_X_ENUM  = 2'd2,
        REG_Z_ENUM  = 2'd3
    } reg_idx_t;

endpackage

// ----- hdl/gmbl_divider.sv -----
// Restoring divider, one quotient bit per cycle, with half-up rounding.
// Depends on gmbl_pkg.
module gmbl_divider #(
    parameter int VW = gmbl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VW:0]                   numer,
    input  logic [VW:0]                   denom,
    output logic                          done,
    output logic [gmbl_pkg::WEIGHT_W-1:0] quot
);
    import gmbl_pkg::*;

    // numer < denom, so quotient of numer<<16 / denom fits in 16 bits
    localparam int RW = VW + 2;

    logic [RW-1:0]       rem_reg, rem_next;
    logic [RW-1:0]       den_reg, den_next;
    logic [FRAC_W-1:0]   q_reg, q_next;
    logic [FRAC_W-1:0]   nbits_reg, nbits_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [RW-1:0]       shifted;
    logic [RW:0]         twice;

    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        shifted    = {rem_reg[RW-2:0], 1'b0};
        twice      = {rem_reg, 1'b0};
        if (start)
        begin
            rem_next  = {1'b0, numer};
            den_next  = {1'b0, denom};
            q_next    = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'(FRAC_W))
            begin
                // round half up: 2*rem >= den
                busy_next = 1'b0;
                done_next = 1'b1;
                if (twice >= {1'b0, den_reg})
                    q_next = q_reg + 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                if (shifted >= den_reg)
                begin
                    rem_next = shifted - den_reg;
                    q_next   = {q_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    q_next   = {q_reg[FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    // q may wrap to zero on round-up only when it was all ones; track carry
    always_comb
    begin
        nbits_next = nbits_reg;
        if (start)
            nbits_next = '0;
        else if (busy_reg && cnt_reg == 5'(FRAC_W) && twice >= {1'b0, den_reg}
                 && q_reg == {FRAC_W{1'b1}})
            nbits_next = {{(FRAC_W-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
            nbits_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            nbits_reg <= nbits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = {nbits_reg[0], q_reg};
endmodule

// ----- hdl/grid_map_bilinear_lookup.sv -----
// Top level of the bilinear grid lookup: memories, sequencer, output register.
// Depends on gmbl_pkg and gmbl_divider.
//
// Loads (kind 0..2) write one X breakpoint, Z breakpoint or grid entry and
// produce no output transaction. A query scans the X breakpoints one at a
// time (one memory read port, registered data), divides for the X fraction
// on the shared bit-serial divider, then does the same for Z, then forms the
// corner weights on one shared 17x17 multiplier, sorts them, and reads each
// corner's breakpoints and grid value one at a time while accumulating the
// blend. A query stalls while the output register holds a corner not yet
// taken; in_ready is low for the whole query. Corners leave through an output
// register, with last set and blended valid on the final one. Breakpoint
// and grid stores have no reset; reading an unwritten entry gives
// undefined fields.
module grid_map_bilinear_lookup
    import gmbl_pkg::*;
#(
    parameter int MAX_X_POINTS = MAX_X_POINTS_DEF,
    parameter int MAX_Z_POINTS = MAX_Z_POINTS_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [gmbl_pkg::CNT_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic [gmbl_pkg::SLOT_W-1:0] slot,
    input  logic signed [31:0]         load_value,
    input  logic signed [31:0]         query_x,
    input  logic signed [31:0]         query_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         corner_x,
    output logic signed [31:0]         corner_z,
    output logic [gmbl_pkg::SLOT_W-1:0] grid_index,
    output logic signed [31:0]         corner_value,
    output logic [gmbl_pkg::WEIGHT_W-1:0] weight,
    output logic signed [31:0]         blended,
    output logic                       last
);
    import gmbl_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int XA_W  = $clog2(MAX_X_POINTS);
    localparam int ZA_W  = $clog2(MAX_Z_POINTS);
    localparam int GDEP  = MAX_X_POINTS * MAX_Z_POINTS;
    localparam int GA_W  = $clog2(GDEP);
    localparam int XC_W  = XA_W + 1;
    localparam int ZC_W  = ZA_W + 1;
    localparam int IC_W  = (XC_W > ZC_W) ? XC_W : ZC_W;
    localparam int OW    = (VW < 32) ? VW : 32;
    localparam int ACC_W = VW + 20;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_LOAD  = 13'b0000000000010,
        S_SCAN  = 13'b0000000000100,
        S_CMP   = 13'b0000000001000,
        S_PREV  = 13'b0000000010000,
        S_DIV   = 13'b0000000100000,
        S_AXEND = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_SORT  = 13'b0000100000000,
        S_RD    = 13'b0001000000000,
        S_ACC   = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_WAIT  = 13'b1000000000000
    } state_t;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] xcnt_reg, zcnt_reg;
    logic             xen_reg, zen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xcnt_reg <= CNT_W'(1);
            zcnt_reg <= CNT_W'(1);
            xen_reg  <= 1'b0;
            zen_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_X_COUNT: xcnt_reg <= cfg_data;
                REG_Z_COUNT: zcnt_reg <= cfg_data;
                REG_X_ENUM:  xen_reg  <= cfg_data[0];
                REG_Z_ENUM:  zen_reg  <= cfg_data[0];
                default:     xen_reg  <= xen_reg;
            endcase
        end
    end

    // effective counts: 0 acts as 1, clamp to maximum
    logic [XC_W-1:0] nx;
    logic [ZC_W-1:0] nz;
    always_comb
    begin
        if (xcnt_reg == '0)
            nx = XC_W'(1);
        else if (32'(xcnt_reg) > MAX_X_POINTS)
            nx = XC_W'(MAX_X_POINTS);
        else
            nx = XC_W'(xcnt_reg);
        if (zcnt_reg == '0)
            nz = ZC_W'(1);
        else if (32'(zcnt_reg) > MAX_Z_POINTS)
            nz = ZC_W'(MAX_Z_POINTS);
        else
            nz = ZC_W'(zcnt_reg);
    end

    // ---------------- input capture ----------------
    state_t state_reg, state_next;
    logic [1:0]           kind_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic signed [VW-1:0] lval_reg, qx_reg, qz_reg;

    assign in_ready = (state_reg == S_IDLE);
    wire in_fire = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            lval_reg <= VW'(load_value);
            qx_reg   <= VW'(query_x);
            qz_reg   <= VW'(query_z);
        end
    end

    // ---------------- memories ----------------
    logic signed [VW-1:0] xmem [MAX_X_POINTS];
    logic signed [VW-1:0] zmem [MAX_Z_POINTS];
    logic signed [VW-1:0] gmem [GDEP];
    logic [XA_W-1:0]      xra;
    logic [ZA_W-1:0]      zra;
    logic [GA_W-1:0]      gra;
    logic signed [VW-1:0] xrd_reg, zrd_reg, grd_reg;

    wire do_load = (state_reg == S_LOAD);
    always_ff @(posedge clk)
    begin
        if (do_load && kind_t'(kind_reg) == KIND_LOAD_X && 32'(slot_reg) < MAX_X_POINTS)
            xmem[slot_reg[XA_W-1:0]] <= lval_reg;
        xrd_reg <= xmem[xra];
    end
    always_ff @(posedge clk)
    begin
        if (do_load && kind_t'(kind_reg) == KIND_LOAD_Z && 32'(slot_reg) < MAX_Z_POINTS)
            zmem[slot_reg[ZA_W-1:0]] <= lval_reg;
        zrd_reg <= zmem[zra];
    end
    always_ff @(posedge clk)
    begin
        if (do_load && kind_t'(kind_reg) == KIND_LOAD_G && 32'(slot_reg) < GDEP)
            gmem[slot_reg[GA_W-1:0]] <= lval_reg;
        grd_reg <= gmem[gra];
    end

    // ---------------- axis search ----------------
    logic                 axis_reg, axis_next;          // 0 = X, 1 = Z
    logic [IC_W-1:0]      idx_reg, idx_next;            // wide enough for both axes
    logic signed [VW-1:0] cur_reg, cur_next;            // breakpoint at idx
    logic signed [VW-1:0] prv_reg, prv_next;            // breakpoint at idx-1
    logic [IC_W-1:0]      li_reg, li_next, ri_reg, ri_next;
    logic                 hasr_reg, hasr_next;
    logic [WEIGHT_W-1:0]  lw_reg, lw_next;
    // per-axis results
    logic [XA_W-1:0]      lx_reg, lx_next, rx_reg, rx_next;
    logic [ZA_W-1:0]      lz_reg, lz_next, rz_reg, rz_next;
    logic                 hrx_reg, hrx_next, hrz_reg, hrz_next;
    logic [WEIGHT_W-1:0]  wx_reg, wx_next, wz_reg, wz_next;

    wire [IC_W-1:0]       n_axis = axis_reg ? IC_W'(nz) : IC_W'(nx);
    wire                  en_axis = axis_reg ? zen_reg : xen_reg;
    wire signed [VW-1:0]  q_axis = axis_reg ? qz_reg : qx_reg;
    wire signed [VW-1:0]  rd_axis = axis_reg ? zrd_reg : xrd_reg;

    // divider
    logic                 div_start;
    logic                 div_done;
    logic [WEIGHT_W-1:0]  div_q;
    wire signed [VW:0]    range_s = {cur_reg[VW-1], cur_reg} - {prv_reg[VW-1], prv_reg};
    wire signed [VW:0]    pos_s   = {q_axis[VW-1], q_axis} - {prv_reg[VW-1], prv_reg};
    wire                  frac_ok = (range_s > 0) && (pos_s >= 0) && (pos_s < range_s);

    gmbl_divider #(.VW(VW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (pos_s),
        .denom (range_s),
        .done  (div_done),
        .quot  (div_q)
    );

    // ---------------- corners ----------------
    logic [1:0]          ncor_reg, ncor_next;           // corner count - 1
    logic [WEIGHT_W-1:0] cw_reg [4];
    logic [WEIGHT_W-1:0] cw_next [4];
    logic [1:0]          cid_reg [4];                   // corner code: bit1 rx, bit0 rz
    logic [1:0]          cid_next [4];
    logic [1:0]          ci_reg, ci_next;               // working corner / sort step

    // shared multiplier, one product per cycle
    logic [WEIGHT_W-1:0] ma, mb;
    logic [2*WEIGHT_W-1:0] prod;
    assign prod = ma * mb;

    // accumulation of the plain Q16 weighted sum in one full-width register
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [VW+WEIGHT_W:0] vprod;
    assign vprod = grd_reg * $signed({1'b0, cw_reg[ci_reg]});

    // output register
    logic                 ov_reg, ov_next;
    logic signed [31:0]   ox_reg, oz_reg, ov_val_reg, obl_reg;
    logic [SLOT_W-1:0]    ogi_reg;
    logic [WEIGHT_W-1:0]  ow_reg;
    logic                 olast_reg;
    logic                 out_load;

    logic [XA_W-1:0] cxi;
    logic [ZA_W-1:0] czi;
    logic [GA_W+1:0] gidx;
    always_comb
    begin
        cxi  = cid_reg[ci_reg][1] ? rx_reg : lx_reg;
        czi  = cid_reg[ci_reg][0] ? rz_reg : lz_reg;
        gidx = (GA_W+2)'(cxi) + (GA_W+2)'(czi) * (GA_W+2)'(nx);
    end

    // saturated blend
    logic signed [ACC_W-1:0] sum_r;
    logic signed [31:0]      sat;
    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'((64'sd1 <<< (OW-1)) - 1);
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - 1;
    always_comb
    begin
        sum_r = (acc_reg + ACC_W'(32768)) >>> 16;
        if (sum_r > LIM_HI)
            sat = 32'(LIM_HI);
        else if (sum_r < LIM_LO)
            sat = 32'(LIM_LO);
        else
            sat = 32'(sum_r);
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        prv_next   = prv_reg;
        li_next    = li_reg;
        ri_next    = ri_reg;
        hasr_next  = hasr_reg;
        lw_next    = lw_reg;
        lx_next    = lx_reg;  rx_next = rx_reg;  hrx_next = hrx_reg;  wx_next = wx_reg;
        lz_next    = lz_reg;  rz_next = rz_reg;  hrz_next = hrz_reg;  wz_next = wz_reg;
        ncor_next  = ncor_reg;
        ci_next    = ci_reg;
        acc_next   = acc_reg;
        cw_next    = cw_reg;
        cid_next   = cid_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        xra        = XA_W'(idx_reg);
        zra        = ZA_W'(idx_reg);
        gra        = gidx[GA_W-1:0];
        ma         = wx_reg;
        mb         = wz_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind_t'(kind) == KIND_QUERY)
                    begin
                        state_next = S_SCAN;
                        axis_next  = 1'b0;
                        idx_next   = '0;
                    end
                    else
                        state_next = S_LOAD;
                end
            end
            S_LOAD:
                state_next = S_IDLE;
            S_SCAN:
            begin
                // read address idx this cycle; data ready next cycle
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cur_next = rd_axis;
                if (rd_axis == q_axis)
                begin
                    li_next = idx_reg; hasr_next = 1'b0; lw_next = ONE_Q16;
                    state_next = S_AXEND;
                end
                else if (rd_axis > q_axis)
                begin
                    if (idx_reg == '0)
                    begin
                        li_next = '0; hasr_next = 1'b0; lw_next = ONE_Q16;
                        state_next = S_AXEND;
                    end
                    else
                    begin
                        li_next = idx_reg - 1'b1; ri_next = idx_reg; hasr_next = 1'b1;
                        idx_next = idx_reg - 1'b1;
                        xra = XA_W'(idx_reg - 1'b1);
                        zra = ZA_W'(idx_reg - 1'b1);
                        state_next = S_PREV;
                    end
                end
                else if (idx_reg + 1'b1 >= n_axis)
                begin
                    li_next = n_axis - 1'b1; hasr_next = 1'b0; lw_next = ONE_Q16;
                    state_next = S_AXEND;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_PREV:
            begin
                // address idx-1 was presented last cycle in S_CMP
                if (prv_reg == rd_axis && 1'b0) prv_next = prv_reg;
                prv_next   = rd_axis;
                state_next = S_DIV;
                div_start  = 1'b0;
            end
            S_DIV:
            begin
                if (!frac_ok)
                begin
                    lw_next    = ONE_Q16;
                    state_next = S_AXEND;
                end
                else if (div_done)
                begin
                    lw_next    = ONE_Q16 - div_q;
                    state_next = S_AXEND;
                end
                else if (ci_reg == 2'd0)
                begin
                    div_start = 1'b1;
                    ci_next   = 2'd1;
                end
            end
            S_AXEND:
            begin
                ci_next = 2'd0;
                if (!axis_reg)
                begin
                    if (xen_reg)
                    begin
                        lx_next = (lw_reg < ONE_Q16 - lw_reg) ? XA_W'(ri_reg)
                                                               : XA_W'(li_reg);
                        hrx_next = 1'b0; wx_next = ONE_Q16;
                    end
                    else
                    begin
                        lx_next = XA_W'(li_reg); rx_next = XA_W'(ri_reg);
                        hrx_next = hasr_reg; wx_next = lw_reg;
                    end
                    axis_next  = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    if (zen_reg)
                    begin
                        lz_next = (lw_reg < ONE_Q16 - lw_reg) ? ZA_W'(ri_reg) : ZA_W'(li_reg);
                        hrz_next = 1'b0; wz_next = ONE_Q16;
                    end
                    else
                    begin
                        lz_next = ZA_W'(li_reg); rz_next = ZA_W'(ri_reg);
                        hrz_next = hasr_reg; wz_next = lw_reg;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // ci: 0 xL zL, 1 xL zR, 2 xR zL, 3 xR zR
                ma = ci_reg[1] ? ONE_Q16 - wx_reg : wx_reg;
                mb = ci_reg[0] ? ONE_Q16 - wz_reg : wz_reg;
                cw_next[ci_reg]  = WEIGHT_W'((prod + 34'd32768) >> 16);
                cid_next[ci_reg] = ci_reg;
                if (ci_reg == 2'd3)
                begin
                    state_next = S_SORT;
                    ci_next    = 2'd0;
                    // compact present corners
                    if (hrx_reg && hrz_reg)
                        ncor_next = 2'd3;
                    else if (hrz_reg)
                        ncor_next = 2'd1;
                    else if (hrx_reg)
                    begin
                        ncor_next   = 2'd1;
                        cw_next[1]  = cw_reg[2];
                        cid_next[1] = 2'd2;
                    end
                    else
                        ncor_next = 2'd0;
                end
                else
                    ci_next = ci_reg + 1'b1;
            end
            S_SORT:
            begin
                // bubble passes over at most four entries, one compare per cycle
                if (ci_reg < ncor_reg)
                begin
                    if (cw_reg[ci_reg] < cw_reg[ci_reg + 1'b1])
                    begin
                        cw_next[ci_reg]         = cw_reg[ci_reg + 1'b1];
                        cw_next[ci_reg + 1'b1]  = cw_reg[ci_reg];
                        cid_next[ci_reg]        = cid_reg[ci_reg + 1'b1];
                        cid_next[ci_reg + 1'b1] = cid_reg[ci_reg];
                        ci_next = 2'd0;
                    end
                    else
                        ci_next = ci_reg + 1'b1;
                end
                else
                begin
                    ci_next    = 2'd0;
                    acc_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                xra        = cxi;
                zra        = czi;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // keep the corner's breakpoints on the read ports
                xra        = cxi;
                zra        = czi;
                acc_next   = acc_reg + ACC_W'(vprod);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                xra = cxi;
                zra = czi;
                if (!ov_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (ci_reg == ncor_reg)
                        state_next = S_WAIT;
                    else
                    begin
                        ci_next    = ci_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_WAIT:
            begin
                ci_next = 2'd0;
                if (!ov_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ci_reg    <= 2'd0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ci_reg    <= ci_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        prv_reg  <= prv_next;
        li_reg   <= li_next;
        ri_reg   <= ri_next;
        hasr_reg <= hasr_next;
        lw_reg   <= lw_next;
        lx_reg   <= lx_next;  rx_reg <= rx_next;  hrx_reg <= hrx_next;  wx_reg <= wx_next;
        lz_reg   <= lz_next;  rz_reg <= rz_next;  hrz_reg <= hrz_next;  wz_reg <= wz_next;
        ncor_reg <= ncor_next;
        acc_reg  <= acc_next;
        cw_reg   <= cw_next;
        cid_reg  <= cid_next;
    end

    // ---------------- output register ----------------
    always_comb
    begin
        ov_next = ov_reg;
        if (out_load)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ox_reg     <= 32'(xrd_reg);
            oz_reg     <= 32'(zrd_reg);
            ogi_reg    <= SLOT_W'(gidx);
            ov_val_reg <= 32'(grd_reg);
            ow_reg     <= cw_reg[ci_reg];
            olast_reg  <= (ci_reg == ncor_reg);
            obl_reg    <= (ci_reg == ncor_reg) ? sat : 32'sd0;
        end
    end

    assign out_valid    = ov_reg;
    assign corner_x     = ox_reg;
    assign corner_z     = oz_reg;
    assign grid_index   = ogi_reg;
    assign corner_value = ov_val_reg;
    assign weight       = ow_reg;
    assign blended      = obl_reg;
    assign last         = olast_reg;
endmodule

// ----- hdl/gmbl_checker.sv -----
// Port-level checks for the bilinear grid lookup, bound to the top level.
// Depends on grid_map_bilinear_lookup.
module gmbl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] weight,
    input logic [31:0] blended,
    input logic        last
);
    // a held result stays valid, with weight and last unchanged, until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(last))
        else $error("output transaction changed while stalled");

    // one item at a time: an accepted input drops in_ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // weights never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= 17'h10000)
        else $error("weight above one");

    // blend is zero except on the last corner
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> blended == 32'd0)
        else $error("blend on non-final corner");
endmodule

bind grid_map_bilinear_lookup gmbl_checker u_gmbl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .weight    (weight),
    .blended   (blended),
    .last      (last)
);
